/* rtl/core/gicr_pkg.sv */
// ----------------------------------------------------------------------------
// gicr_pkg
// Shared types, widths and codes of the gradient intersection corner refiner.
// ----------------------------------------------------------------------------
`default_nettype none

package gicr_pkg;

    // Field and accumulator widths.
    localparam int GRAD_W  = 16;
    localparam int COORD_W = 12;
    localparam int RAD_W   = 4;
    localparam int FRAC_W  = 4;
    localparam int SQ_W    = 40;
    localparam int PROJ_W  = 54;
    localparam int OUT_W   = 16;
    localparam int STAT_W  = 2;

    // Projection p = py*gy + px*gx and its products with the gradient.
    localparam int PRJ_W = COORD_W + GRAD_W + 2;
    localparam int PP_W  = GRAD_W + PRJ_W;

    // Solver widths: signed operand, digit of the multiplier, Cramer terms.
    localparam int OPA_W   = PROJ_W;
    localparam int OPB_W   = 64;
    localparam int DIG_W   = 16;
    localparam int MUL_W   = OPA_W + DIG_W + 1;
    localparam int ACC_W   = 96;
    localparam int DVD_W   = ACC_W + FRAC_W;
    localparam int CNT_W   = 7;

    // Sequencer last-step indexes.
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(6 * (OPB_W / DIG_W) - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd1;
    localparam logic [STAT_W-1:0] ST_BORDER   = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [RAD_W-1:0]   RADIUS_RST = 4'd3;
    localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd480;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_SOLVE,
        S_TEST,
        S_DIV,
        S_DIV_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [RAD_W-1:0]   radius;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       mul1;
        logic       mul2;
        logic       acc;
        logic       mul_step;
        logic [2:0] sel;
        logic [1:0] digit;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic       axis;
        logic       out_load;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic det_zero;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/gradient_intersection_corner_refine_unit.sv */
// ----------------------------------------------------------------------------
// gradient_intersection_corner_refine_unit
// Gradient-line intersection corner refinement over one window of samples.
// ----------------------------------------------------------------------------
// Each sample passes through capture, two multiply stages and accumulate;
// s_tready is high again once the sample is accumulated, not before.
// On the last sample, the digit-serial multiplier (54-bit operand by 16-bit
// digits of a 64-bit operand) forms the Cramer terms, then two restoring
// divisions run, one per axis; a singular window skips both divisions.
// Synchronous active-low reset restores register defaults and clears the sums.
`default_nettype none

module gradient_intersection_corner_refine_unit
    import gicr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Sample stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: grad_x[15:0], grad_y[31:16], pixel_x[43:32], pixel_y[55:44].
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tlast,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: corner_x[15:0], corner_y[31:16].
    output logic [31:0]      m_tdata,
    // m_tuser: status[1:0].
    output logic [1:0]       m_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // Configuration registers.
    gicr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer.
    gicr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    // Arithmetic and result register.
    gicr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (cfg),
        .i_s_data  (s_tdata),
        .i_s_last  (s_tlast),
        .i_m_ready (m_tready),
        .o_m_valid (m_tvalid),
        .o_m_data  (m_tdata),
        .o_m_user  (m_tuser),
        .o_stat    (stat)
    );

endmodule

`default_nettype wire

/* rtl/core/gicr_regs.sv */
// ----------------------------------------------------------------------------
// gicr_regs
// Configuration register file on a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module gicr_regs
    import gicr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [RAD_W-1:0]   r_radius;
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes at the access phase of a write request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[COORD_W-1:0];
                REG_HEIGHT: r_height <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = {{(32-RAD_W){1'b0}}, r_radius};
            REG_WIDTH:  prdata = {{(32-COORD_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-COORD_W){1'b0}}, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{radius: r_radius, width: r_width, height: r_height};

endmodule

`default_nettype wire

/* rtl/core/gicr_ctrl.sv */
// ----------------------------------------------------------------------------
// gicr_ctrl
// Sequencer: sample accumulation steps, Cramer products, divisions, output.
// ----------------------------------------------------------------------------
`default_nettype none

module gicr_ctrl
    import gicr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_axis, n_axis;

    // State, step counter and axis registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_axis   = r_axis;
        s_tready = 1'b0;
        o_cmd    = '0;
        o_cmd.sel   = r_cnt[4:2];
        o_cmd.digit = r_cnt[1:0];
        o_cmd.axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt     = '0;
                n_state   = i_stat.last ? S_SOLVE : S_IDLE;
            end
            S_SOLVE: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                // A zero determinant skips both divisions; otherwise load the
                // divider for the current axis.
                if (i_stat.det_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_store = 1'b1;
                if (!r_axis) begin
                    // Column quotient stored; the row is loaded next cycle.
                    n_axis  = 1'b1;
                    n_state = S_TEST;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_axis         = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/gicr_dp.sv */
// ----------------------------------------------------------------------------
// gicr_dp
// Datapath: normal-matrix sums, digit-serial multiplier, restoring divider,
// border check and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gicr_dp
    import gicr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire t_cfg                i_cfg,
    input  wire logic [55:0]         i_s_data,
    input  wire logic                i_s_last,
    input  wire logic                i_m_ready,
    output logic                     o_m_valid,
    output logic [2*OUT_W-1:0]       o_m_data,
    output logic [STAT_W-1:0]        o_m_user,
    output t_stat                    o_stat
);

    // Captured sample.
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [COORD_W-1:0]       r_px, r_py;
    logic                     r_last;

    // Per-sample products.
    logic signed [2*GRAD_W-1:0] r_sq_yy, r_sq_xx, r_sq_yx;
    logic signed [PRJ_W-1:0]    r_proj;
    logic signed [PP_W-1:0]     r_pp_y, r_pp_x;

    // Window sums.
    logic [SQ_W-1:0]   r_sum_yy, r_sum_xx, r_sum_yx;
    logic [PROJ_W-1:0] r_sum_yp, r_sum_xp;

    // Cramer terms.
    logic signed [ACC_W-1:0] r_acc, r_det, r_nx, r_ny;

    // Divider.
    logic [DVD_W-1:0] r_dvd, r_q;
    logic [ACC_W-1:0] r_den, r_rem;
    logic             r_neg;

    // Per-axis results.
    logic             r_ok_x, r_ok_y;
    logic [OUT_W-1:0] r_cx, r_cy;

    // Output register.
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_x, r_out_y;
    logic [STAT_W-1:0]   r_out_st;

    // Sample capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx   <= i_s_data[15:0];
            r_gy   <= i_s_data[31:16];
            r_px   <= i_s_data[43:32];
            r_py   <= i_s_data[55:44];
            r_last <= i_s_last;
        end
    end

    // First multiply stage: gradient squares and the projection.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_sq_yy <= r_gy * r_gy;
            r_sq_xx <= r_gx * r_gx;
            r_sq_yx <= r_gy * r_gx;
            r_proj  <= $signed({1'b0, r_py}) * r_gy + $signed({1'b0, r_px}) * r_gx;
        end
    end

    // Second multiply stage: gradient times projection.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_pp_y <= r_gy * r_proj;
            r_pp_x <= r_gx * r_proj;
        end
    end

    // Window sums wrap modulo their widths and clear after each result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum_yy <= '0;
            r_sum_xx <= '0;
            r_sum_yx <= '0;
            r_sum_yp <= '0;
            r_sum_xp <= '0;
        end else if (i_cmd.acc) begin
            r_sum_yy <= r_sum_yy + {{(SQ_W-2*GRAD_W){r_sq_yy[2*GRAD_W-1]}}, r_sq_yy};
            r_sum_xx <= r_sum_xx + {{(SQ_W-2*GRAD_W){r_sq_xx[2*GRAD_W-1]}}, r_sq_xx};
            r_sum_yx <= r_sum_yx + {{(SQ_W-2*GRAD_W){r_sq_yx[2*GRAD_W-1]}}, r_sq_yx};
            r_sum_yp <= r_sum_yp + {{(PROJ_W-PP_W){r_pp_y[PP_W-1]}}, r_pp_y};
            r_sum_xp <= r_sum_xp + {{(PROJ_W-PP_W){r_pp_x[PP_W-1]}}, r_pp_x};
        end
    end

    // Operand selection for the six Cramer products.
    logic signed [OPA_W-1:0] g11_a, g12_a, r1_a, r2_a, op_a;
    logic signed [OPB_W-1:0] g22_b, g12_b, r1_b, r2_b, op_b;
    logic signed [DIG_W:0]   dig;
    logic signed [MUL_W-1:0] pp;
    logic signed [ACC_W-1:0] pp_sh, acc_base, acc_next;
    logic [5:0]              sh_amt;

    assign g11_a = {{(OPA_W-SQ_W){1'b0}}, r_sum_yy};
    assign g12_a = {{(OPA_W-SQ_W){r_sum_yx[SQ_W-1]}}, r_sum_yx};
    assign r1_a  = r_sum_yp;
    assign r2_a  = r_sum_xp;
    assign g22_b = {{(OPB_W-SQ_W){1'b0}}, r_sum_xx};
    assign g12_b = {{(OPB_W-SQ_W){r_sum_yx[SQ_W-1]}}, r_sum_yx};
    assign r1_b  = {{(OPB_W-PROJ_W){r_sum_yp[PROJ_W-1]}}, r_sum_yp};
    assign r2_b  = {{(OPB_W-PROJ_W){r_sum_xp[PROJ_W-1]}}, r_sum_xp};

    always_comb begin
        unique case (i_cmd.sel)
            3'd0:    begin op_a = g11_a; op_b = g22_b; end
            3'd1:    begin op_a = g12_a; op_b = g12_b; end
            3'd2:    begin op_a = g11_a; op_b = r2_b;  end
            3'd3:    begin op_a = g12_a; op_b = r1_b;  end
            3'd4:    begin op_a = r1_a;  op_b = g22_b; end
            default: begin op_a = g12_a; op_b = r2_b;  end
        endcase
    end

    // One 16-bit digit of the second operand a cycle; the top digit is signed.
    always_comb begin
        unique case (i_cmd.digit)
            2'd0:    dig = $signed({1'b0, op_b[15:0]});
            2'd1:    dig = $signed({1'b0, op_b[31:16]});
            2'd2:    dig = $signed({1'b0, op_b[47:32]});
            default: dig = $signed({op_b[63], op_b[63:48]});
        endcase
    end

    assign pp       = op_a * dig;
    assign sh_amt   = {i_cmd.digit, 4'b0000};
    assign pp_sh    = $signed({{(ACC_W-MUL_W){pp[MUL_W-1]}}, pp}) <<< sh_amt;
    assign acc_base = (i_cmd.digit == 2'd0 && !i_cmd.sel[0]) ? '0 : r_acc;
    assign acc_next = i_cmd.sel[0] ? acc_base - pp_sh : acc_base + pp_sh;

    // Even products add, odd products subtract and close a Cramer term.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_acc <= acc_next;
            if (i_cmd.digit == 2'd3 && i_cmd.sel[0]) begin
                unique case (i_cmd.sel[2:1])
                    2'd0:    r_det <= acc_next;
                    2'd1:    r_nx  <= acc_next;
                    default: r_ny  <= acc_next;
                endcase
            end
        end
    end

    // Restoring division of |num| * 2^FRAC_W by |det|, one quotient bit a cycle.
    logic signed [ACC_W-1:0] num;
    logic [ACC_W-1:0]        num_abs, det_abs;
    logic [ACC_W:0]          rem_sh;
    logic                    rem_ge;

    assign num     = i_cmd.axis ? r_ny : r_nx;
    assign num_abs = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign det_abs = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= {num_abs, {FRAC_W{1'b0}}};
            r_den <= det_abs;
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= num[ACC_W-1] ^ r_det[ACC_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? ACC_W'(rem_sh - {1'b0, r_den}) : ACC_W'(rem_sh);
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_q   <= {r_q[DVD_W-2:0], rem_ge};
        end
    end

    // Border margin: (r+2)*16 <= q <= (size-r-3)*16; a negative bound fails.
    logic [OUT_W-1:0]         low_b, high_b;
    logic signed [COORD_W+1:0] high_raw;
    logic [COORD_W-1:0]       size_sel;
    logic                     q_ok;

    assign size_sel = i_cmd.axis ? i_cfg.height : i_cfg.width;
    assign low_b    = OUT_W'({1'b0, i_cfg.radius} + 5'd2) << FRAC_W;
    assign high_raw = $signed({2'b00, size_sel}) - $signed({{(COORD_W-2){1'b0}}, i_cfg.radius})
                      - $signed((COORD_W+2)'(3));
    assign high_b   = {high_raw[COORD_W-1:0], {FRAC_W{1'b0}}};
    assign q_ok     = !r_neg && (r_q[DVD_W-1:OUT_W] == '0) && !high_raw[COORD_W+1]
                      && (r_q[OUT_W-1:0] >= low_b) && (r_q[OUT_W-1:0] <= high_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (i_cmd.axis) begin
                r_ok_y <= q_ok;
                r_cy   <= r_q[OUT_W-1:0];
            end else begin
                r_ok_x <= q_ok;
                r_cx   <= r_q[OUT_W-1:0];
            end
        end
    end

    // Output register: holds one result until the downstream request is taken.
    logic det_zero;

    assign det_zero = (r_det == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (det_zero) begin
                r_out_st <= ST_SINGULAR;
                r_out_x  <= '0;
                r_out_y  <= '0;
            end else if (r_ok_x && r_ok_y) begin
                r_out_st <= ST_OK;
                r_out_x  <= r_cx;
                r_out_y  <= r_cy;
            end else begin
                r_out_st <= ST_BORDER;
                r_out_x  <= '0;
                r_out_y  <= '0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {r_out_y, r_out_x};
    assign o_m_user  = r_out_st;

    assign o_stat = '{last: r_last, det_zero: det_zero,
                      out_free: !r_out_valid || i_m_ready};

endmodule

`default_nettype wire
